### rtl/core/dpcm_pkg.sv
// ----------------------------------------------------------------------------
// dpcm_pkg
// Shared types and constants for the DMA-fed PCM audio register block.
// ----------------------------------------------------------------------------
package dpcm_pkg;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DMA   = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int INDEX_SPAN        = 16;

  localparam logic [3:0] OFS_MODE     = 4'h0;
  localparam logic [3:0] OFS_TBL0     = 4'h2;
  localparam logic [3:0] OFS_IDX0     = 4'h3;
  localparam logic [3:0] OFS_TBL1     = 4'h4;
  localparam logic [3:0] OFS_IDX1     = 4'h5;
  localparam logic [3:0] OFS_STATUS   = 4'h9;
  localparam logic [3:0] OFS_COUNT_LO = 4'hc;
  localparam logic [3:0] OFS_COUNT_HI = 4'he;

  localparam logic [7:0] MODE_FMT_MASK = 8'h88;
  localparam logic [7:0] FMT_8_MONO    = 8'h80;
  localparam logic [7:0] FMT_8_STEREO  = 8'h00;
  localparam logic [7:0] FMT_16_MONO   = 8'h88;
  localparam int         MODE_RUN_BIT  = 4;

  localparam logic [2:0] STATUS_END = 3'd4;

  typedef struct packed {
    logic [1:0]  rate_select;
    logic        playing;
    logic        irq_line;
    logic        dma_request;
    logic [15:0] right_sample;
    logic [15:0] left_sample;
    logic [7:0]  read_data;
  } out_data_t;

  typedef struct packed {
    logic eight_bit;
    logic sample_valid;
  } out_user_t;

endpackage

### rtl/core/dma_pcm_audio_register_block.sv
// ----------------------------------------------------------------------------
// dma_pcm_audio_register_block
// PCM audio card behind byte registers, fed by DMA words and rate ticks.
// ----------------------------------------------------------------------------
// an accepted word's result is in the output register in the next cycle
// throughput: one word per cycle while out_tready keeps the output register free,
// set by the single state update per word; the output register frees its slot in the same cycle it is taken
// reset: synchronous active-low rst_n clears mode, count, cursor, indexes,
// status and line levels; table bytes and sample words hold until written
module dma_pcm_audio_register_block
  import dpcm_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // reg_offset[3:0], bus_value[19:4], zero pad
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_data, left_sample, right_sample,
                                  // dma_request, irq_line, playing,
                                  // rate_select[44:43], zero pad
  output logic [1:0]  out_tuser   // sample_valid, eight_bit
);

  localparam int TBL_DEPTH = (TABLE_ENTRIES < INDEX_SPAN) ? TABLE_ENTRIES : INDEX_SPAN;
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  logic [7:0]  mode_r, mode_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] words_r [2];
  logic [1:0]  wcnt_r, wcnt_nxt;
  logic [2:0]  cursor_r, cursor_nxt;
  logic [3:0]  idx_r [2];
  logic [3:0]  idx_nxt [2];
  logic [7:0]  tbl_r [2][TBL_DEPTH];
  logic [2:0]  status_r, status_nxt;
  logic        running_r, running_nxt;
  logic        drq_r, drq_nxt;
  logic        irq_r, irq_nxt;

  logic        out_valid_r;
  out_data_t   out_data_r, out_data_nxt;
  out_user_t   out_user_r, out_user_nxt;

  logic        acc;
  kind_t       kind;
  logic [3:0]  ofs;
  logic [15:0] val;
  logic [7:0]  wbyte;
  logic [7:0]  tbl_rd [2];
  logic        tbl_hit [2];
  logic [1:0]  tbl_we;
  logic        word_we;
  logic        cur_hi;
  logic [15:0] cur_word;
  logic [3:0]  cur_sum;
  logic [3:0]  cur_step;

  assign acc        = in_tvalid && in_tready;
  assign in_tready  = rst_n && (!out_valid_r || out_tready);
  assign kind       = kind_t'(in_tuser);
  assign ofs        = in_tdata[3:0];
  assign val        = in_tdata[19:4];
  assign wbyte      = val[7:0];

  always_comb begin
    for (int t = 0; t < 2; t++) begin
      tbl_hit[t] = {28'd0, idx_r[t]} < TBL_DEPTH;
      tbl_rd[t]  = tbl_hit[t] ? tbl_r[t][idx_r[t][TBL_AW-1:0]] : 8'd0;
    end
  end

  assign cur_hi   = cursor_r[1];
  assign cur_word = words_r[cur_hi];

  always_comb begin
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    wcnt_nxt    = wcnt_r;
    cursor_nxt  = cursor_r;
    idx_nxt[0]  = idx_r[0];
    idx_nxt[1]  = idx_r[1];
    status_nxt  = status_r;
    running_nxt = running_r;
    drq_nxt     = drq_r;
    irq_nxt     = irq_r;
    tbl_we      = 2'b00;
    word_we     = 1'b0;
    cur_step    = 4'd0;
    cur_sum     = 4'd0;
    out_data_nxt = '0;
    out_user_nxt = '0;

    case (kind)
      KIND_READ: begin
        case (ofs)
          OFS_MODE:     out_data_nxt.read_data = mode_r;
          OFS_TBL0:     out_data_nxt.read_data = tbl_rd[0];
          OFS_TBL1:     out_data_nxt.read_data = tbl_rd[1];
          OFS_STATUS: begin
            irq_nxt = 1'b0;
            out_data_nxt.read_data = {5'd0, status_r};
          end
          OFS_COUNT_LO: out_data_nxt.read_data = count_r[7:0];
          OFS_COUNT_HI: out_data_nxt.read_data = count_r[15:8];
          default:      out_data_nxt.read_data = 8'd0;
        endcase
      end
      KIND_WRITE: begin
        case (ofs)
          OFS_MODE:     mode_nxt = wbyte;
          OFS_TBL0:     tbl_we[0] = tbl_hit[0];
          OFS_IDX0:     idx_nxt[0] = wbyte[3:0];
          OFS_TBL1:     tbl_we[1] = tbl_hit[1];
          OFS_IDX1:     idx_nxt[1] = wbyte[3:0];
          OFS_COUNT_LO: count_nxt = {count_r[15:8], wbyte};
          OFS_COUNT_HI: count_nxt = {wbyte, count_r[7:0]};
          default:      ;
        endcase
        if (mode_nxt[MODE_RUN_BIT] && count_nxt != 16'd0) begin
          wcnt_nxt    = 2'd0;
          cursor_nxt  = 3'd0;
          status_nxt  = 3'd0;
          drq_nxt     = 1'b1;
          running_nxt = 1'b1;
        end
      end
      KIND_DMA: begin
        if (wcnt_r < 2'd2) begin
          word_we  = 1'b1;
          wcnt_nxt = wcnt_r + 2'd1;
          if (wcnt_r == 2'd1) begin
            drq_nxt = 1'b0;
          end
        end
      end
      default: begin
        if (running_r) begin
          out_user_nxt.sample_valid = 1'b1;
          case (mode_r & MODE_FMT_MASK)
            FMT_8_MONO: begin
              out_data_nxt.left_sample = {8'd0, cursor_r[0] ? cur_word[15:8] : cur_word[7:0]};
              out_data_nxt.right_sample = out_data_nxt.left_sample;
              out_user_nxt.eight_bit = 1'b1;
              cur_step = 4'd1;
            end
            FMT_8_STEREO: begin
              out_data_nxt.left_sample  = {8'd0, cur_word[7:0]};
              out_data_nxt.right_sample = {8'd0, cur_word[15:8]};
              out_user_nxt.eight_bit = 1'b1;
              cur_step = 4'd2;
            end
            FMT_16_MONO: begin
              out_data_nxt.left_sample  = cur_word;
              out_data_nxt.right_sample = cur_word;
              cur_step = 4'd2;
            end
            default: begin
              out_data_nxt.left_sample  = words_r[0];
              out_data_nxt.right_sample = words_r[1];
              cur_step = 4'd4;
            end
          endcase
          cur_sum    = {1'b0, cursor_r} + cur_step;
          cursor_nxt = cur_sum[2:0];
          if (cur_sum >= 4'd4) begin
            cursor_nxt = 3'd0;
            wcnt_nxt   = 2'd0;
            if (count_r != 16'd0) begin
              count_nxt = count_r - 16'd1;
              drq_nxt   = 1'b1;
            end else begin
              out_data_nxt.left_sample  = 16'd0;
              out_data_nxt.right_sample = 16'd0;
              out_user_nxt.eight_bit    = 1'b0;
              status_nxt  = STATUS_END;
              running_nxt = 1'b0;
              irq_nxt     = 1'b1;
            end
          end
        end
      end
    endcase

    out_data_nxt.dma_request = drq_nxt;
    out_data_nxt.irq_line    = irq_nxt;
    out_data_nxt.playing     = running_nxt;
    out_data_nxt.rate_select = mode_nxt[6:5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 8'd0;
      count_r     <= 16'd0;
      wcnt_r      <= 2'd0;
      cursor_r    <= 3'd0;
      idx_r[0]    <= 4'd0;
      idx_r[1]    <= 4'd0;
      status_r    <= 3'd0;
      running_r   <= 1'b0;
      drq_r       <= 1'b0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        mode_r    <= mode_nxt;
        count_r   <= count_nxt;
        wcnt_r    <= wcnt_nxt;
        cursor_r  <= cursor_nxt;
        idx_r[0]  <= idx_nxt[0];
        idx_r[1]  <= idx_nxt[1];
        status_r  <= status_nxt;
        running_r <= running_nxt;
        drq_r     <= drq_nxt;
        irq_r     <= irq_nxt;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and stores without reset
  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
      if (word_we) begin
        words_r[wcnt_r[0]] <= val;
      end
      for (int t = 0; t < 2; t++) begin
        if (tbl_we[t]) begin
          tbl_r[t][idx_r[t][TBL_AW-1:0]] <= wbyte;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_data_r};
  assign out_tuser  = out_user_r;

`ifndef SYNTH
  a_wcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcnt_r <= 2'd2)
    else $error("dma word count beyond two");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r < 3'd4)
    else $error("byte cursor past the buffer");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind == KIND_TICK && !running_r |=> !out_tuser[0])
    else $error("sample driven while stopped");

  a_irq_status: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_r) |-> status_r == STATUS_END)
    else $error("irq raised without end status");

  a_end_mute: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind == KIND_TICK && running_r && !running_nxt |=>
      out_tdata[39:8] == 32'd0 && !out_tuser[1])
    else $error("end of block not muted");
`endif

endmodule
